// File: sv/bdpc_pkg.sv
package bdpc_pkg;

    // width of the quiet and held counters
    localparam int COUNT_BITS = 16;

    // configuration registers are 16 bits each
    localparam int CFG_BITS = 16;
    localparam int CFG_IDX_BITS = 2;

    // compare width covers both a counter and a register
    localparam int CMP_BITS = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_TAKE_SHORT = 3'd1,
        OP_TAKE_START = 3'd2,
        OP_TAKE_LONG  = 3'd3,
        OP_CLEAR_ALL  = 3'd4
    } op_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DEBOUNCE  = 2'd0,
        CFG_LONG_START = 2'd1,
        CFG_RELEASE   = 2'd2
    } cfg_idx_t;

    // button pin levels
    localparam logic LEVEL_PRESSED  = 1'b0;
    localparam logic LEVEL_RELEASED = 1'b1;

    // reset values of the registers
    localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET   = 16'd50;
    localparam logic [CFG_BITS-1:0] LONG_START_RESET = 16'd1000;
    localparam logic [CFG_BITS-1:0] RELEASE_RESET    = 16'd1000;

    // saturating increment of a counter
    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
    endfunction

endpackage

// File: sv/bdpc_if.sv
// request channel: one operation per request
interface bdpc_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic       raw_level;

    modport source (output valid, output operation, output raw_level, input ready);
    modport sink   (input valid, input operation, input raw_level, output ready);
endinterface

// result channel: one result per request
interface bdpc_result_if;
    logic valid;
    logic ready;
    logic accepted_level;
    logic taken_flag;
    logic short_pending;
    logic long_start_pending;
    logic long_release_pending;

    modport source (output valid, output accepted_level, output taken_flag,
                    output short_pending, output long_start_pending,
                    output long_release_pending, input ready);
    modport sink   (input valid, input accepted_level, input taken_flag,
                    input short_pending, input long_start_pending,
                    input long_release_pending, output ready);
endinterface

// File: sv/button_debounce_press_classifier_unit.sv
// path: a request passes the input register, then the state update into the result register
// throughput: one request per cycle while the result side takes its results, a result register parts the two sides
// rate is set by the single update stage that holds all button state
// reset (rst_n low, asynchronous): levels released, counters and flags zero,
// registers back to 50 / 1000 / 1000, both pipeline stages empty
module button_debounce_press_classifier_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    bdpc_item_if.sink                            item,
    bdpc_result_if.source                        result,
    input  logic                                 cfg_write_en,
    input  logic [bdpc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [bdpc_pkg::CFG_BITS-1:0]        cfg_data
);

    localparam int CW = bdpc_pkg::COUNT_BITS;
    localparam int KW = bdpc_pkg::CMP_BITS;

    // configuration registers
    logic [bdpc_pkg::CFG_BITS-1:0] debounce_reg;
    logic [bdpc_pkg::CFG_BITS-1:0] long_start_reg;
    logic [bdpc_pkg::CFG_BITS-1:0] release_reg;

    // input stage
    logic       in_valid_reg;
    logic [2:0] op_reg;
    logic       raw_reg;

    // button state
    logic          latest_reg,     latest_next;
    logic [CW-1:0] quiet_reg,      quiet_next;
    logic          debounced_reg,  debounced_next;
    logic [CW-1:0] held_reg,       held_next;
    logic          short_reg,      short_next;
    logic          start_reg,      start_next;
    logic          start_done_reg, start_done_next;
    logic          long_reg,       long_next;
    logic          taken_next;

    // result stage
    logic out_valid_reg;
    logic taken_reg;
    logic level_out_reg;
    logic short_out_reg;
    logic start_out_reg;
    logic long_out_reg;

    logic advance;
    logic quiet_done;
    logic [CW-1:0] held_inc;

    // the result register frees up when empty or when taken this cycle
    assign advance    = !out_valid_reg || result.ready;
    assign item.ready = !in_valid_reg || advance;

    // configuration writes, unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= bdpc_pkg::DEBOUNCE_RESET;
            long_start_reg <= bdpc_pkg::LONG_START_RESET;
            release_reg    <= bdpc_pkg::RELEASE_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                bdpc_pkg::CFG_DEBOUNCE:   debounce_reg   <= cfg_data;
                bdpc_pkg::CFG_LONG_START: long_start_reg <= cfg_data;
                bdpc_pkg::CFG_RELEASE:    release_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            op_reg  <= item.operation;
            raw_reg <= item.raw_level;
        end
    end

    // state update for the request held in the input register
    always_comb
    begin
        latest_next     = latest_reg;
        quiet_next      = quiet_reg;
        debounced_next  = debounced_reg;
        held_next       = held_reg;
        short_next      = short_reg;
        start_next      = start_reg;
        start_done_next = start_done_reg;
        long_next       = long_reg;
        taken_next      = 1'b0;
        quiet_done      = 1'b0;

        // held time counts while the debounced level is pressed
        held_inc = (debounced_reg == bdpc_pkg::LEVEL_PRESSED)
                   ? bdpc_pkg::sat_inc(held_reg) : held_reg;

        unique case (op_reg)
            bdpc_pkg::OP_TICK:
            begin
                held_next = held_inc;
                // any change of the raw level restarts the quiet time
                if (raw_reg != latest_reg)
                begin
                    latest_next = raw_reg;
                    quiet_next  = '0;
                end
                else
                begin
                    quiet_next = bdpc_pkg::sat_inc(quiet_reg);
                end

                quiet_done = KW'(quiet_next) > KW'(debounce_reg);

                if (quiet_done)
                begin
                    if (latest_next != debounced_reg)
                    begin
                        debounced_next = latest_next;
                        if (latest_next == bdpc_pkg::LEVEL_PRESSED)
                        begin
                            // new press: restart held time and long start
                            held_next       = '0;
                            start_done_next = 1'b0;
                        end
                        else if (KW'(held_inc) > KW'(release_reg))
                        begin
                            long_next = 1'b1;
                        end
                        else
                        begin
                            short_next = 1'b1;
                        end
                    end
                    else if (debounced_reg == bdpc_pkg::LEVEL_PRESSED)
                    begin
                        // long start fires once per press
                        if (!start_done_reg && KW'(held_inc) >= KW'(long_start_reg))
                        begin
                            start_next      = 1'b1;
                            start_done_next = 1'b1;
                        end
                    end
                end
            end
            bdpc_pkg::OP_TAKE_SHORT:
            begin
                taken_next = short_reg;
                short_next = 1'b0;
            end
            bdpc_pkg::OP_TAKE_START:
            begin
                taken_next = start_reg;
                start_next = 1'b0;
            end
            bdpc_pkg::OP_TAKE_LONG:
            begin
                taken_next = long_reg;
                long_next  = 1'b0;
            end
            bdpc_pkg::OP_CLEAR_ALL:
            begin
                // long start stays marked as done
                short_next = 1'b0;
                start_next = 1'b0;
                long_next  = 1'b0;
            end
            default: ;
        endcase
    end

    // button state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latest_reg     <= bdpc_pkg::LEVEL_RELEASED;
            quiet_reg      <= '0;
            debounced_reg  <= bdpc_pkg::LEVEL_RELEASED;
            held_reg       <= '0;
            short_reg      <= 1'b0;
            start_reg      <= 1'b0;
            start_done_reg <= 1'b0;
            long_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                latest_reg     <= latest_next;
                quiet_reg      <= quiet_next;
                debounced_reg  <= debounced_next;
                held_reg       <= held_next;
                short_reg      <= short_next;
                start_reg      <= start_next;
                start_done_reg <= start_done_next;
                long_reg       <= long_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            level_out_reg <= debounced_next;
            taken_reg     <= taken_next;
            short_out_reg <= short_next;
            start_out_reg <= start_next;
            long_out_reg  <= long_next;
        end
    end

    assign result.valid                = out_valid_reg;
    assign result.accepted_level       = level_out_reg;
    assign result.taken_flag           = taken_reg;
    assign result.short_pending        = short_out_reg;
    assign result.long_start_pending   = start_out_reg;
    assign result.long_release_pending = long_out_reg;

endmodule

// File: test/button_debounce_press_classifier_unit_test.sv
module button_debounce_press_classifier_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bdpc_pkg::*;

    // operation codes the block leaves alone, and a register index with no register
    localparam logic [2:0] OP_UNKNOWN_FIRST = 3'd5;
    localparam logic [2:0] OP_UNKNOWN_LAST = 3'd7;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

    // chance in a hundred of an idle cycle, heavy and light
    localparam int BUSY_PCT = 83;
    localparam int LIGHT_PCT = 15;

    // most mismatch lines printed, the count goes on past it
    localparam int PRINT_CAP = 100;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // one result as the block should give it
    typedef struct packed {
        logic accepted_level;
        logic taken_flag;
        logic short_pending;
        logic long_start_pending;
        logic long_release_pending;
    } press_result_t;

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0] cfg_data;

    bdpc_item_if item_ch();
    bdpc_result_if result_ch();

    button_debounce_press_classifier_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item_ch),
        .result       (result_ch),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // results still owed by the block, oldest first
    press_result_t pending_results[$];

    int error_count = 0;
    int requests_sent = 0;
    int hold_left = 0;
    idle_mode_t idle_mode = IDLE_NONE;

    // own copy of the registers
    logic [CFG_BITS-1:0] debounce_limit;
    logic [CFG_BITS-1:0] long_start_limit;
    logic [CFG_BITS-1:0] release_limit;

    // own copy of the button state
    logic last_raw;
    logic [COUNT_BITS-1:0] quiet_cnt;
    logic level_db;
    logic [COUNT_BITS-1:0] held_cnt;
    logic short_flg;
    logic long_start_flg;
    logic long_start_fired;
    logic long_release_flg;

    // clock, 10 ns period
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // overall time limit, far above the slowest correct run
    initial
    begin
        #10ms;
        $display("button_debounce_press_classifier_unit_test NOT OK");
        $finish;
    end

    // result side ready: a counted hold-off comes first, then the idle mode decides
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                case (idle_mode)
                    IDLE_RECEIVER: result_ch.ready <= ($urandom_range(99) >= BUSY_PCT);
                    IDLE_BOTH:     result_ch.ready <= ($urandom_range(99) >= LIGHT_PCT);
                    default:       result_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_CAP)
        begin
            $display("mismatch at %0t: %s", $time, msg);
        end
    endtask

    // compare each result taken by the sink with the oldest one owed
    always @(posedge clk)
    begin
        press_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with no request pending");
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_ch.accepted_level !== want.accepted_level
                    || result_ch.taken_flag !== want.taken_flag
                    || result_ch.short_pending !== want.short_pending
                    || result_ch.long_start_pending !== want.long_start_pending
                    || result_ch.long_release_pending !== want.long_release_pending)
                begin
                    report_mismatch($sformatf(
                        "level/taken/short/start/long got %b%b%b%b%b want %b%b%b%b%b",
                        result_ch.accepted_level, result_ch.taken_flag,
                        result_ch.short_pending, result_ch.long_start_pending,
                        result_ch.long_release_pending, want.accepted_level,
                        want.taken_flag, want.short_pending,
                        want.long_start_pending, want.long_release_pending));
                end
            end
        end
    end

    // state after reset, registers at their reset values
    task automatic clear_button_model();
        debounce_limit = DEBOUNCE_RESET;
        long_start_limit = LONG_START_RESET;
        release_limit = RELEASE_RESET;
        last_raw = LEVEL_RELEASED;
        quiet_cnt = '0;
        level_db = LEVEL_RELEASED;
        held_cnt = '0;
        short_flg = 1'b0;
        long_start_flg = 1'b0;
        long_start_fired = 1'b0;
        long_release_flg = 1'b0;
    endtask

    // advance the button state by one request and give the result it causes
    function automatic press_result_t classify_request(input logic [2:0] op, input logic raw);
        press_result_t res;
        res.taken_flag = 1'b0;
        case (op)
            OP_TICK:
            begin
                // held time only runs while the accepted level is pressed
                if (level_db == LEVEL_PRESSED && held_cnt != COUNT_MAX)
                begin
                    held_cnt = held_cnt + 1'b1;
                end
                // any change of the raw level restarts the quiet time
                if (raw != last_raw)
                begin
                    last_raw = raw;
                    quiet_cnt = '0;
                end
                else if (quiet_cnt != COUNT_MAX)
                begin
                    quiet_cnt = quiet_cnt + 1'b1;
                end
                if (quiet_cnt > debounce_limit)
                begin
                    if (last_raw != level_db)
                    begin
                        level_db = last_raw;
                        if (level_db == LEVEL_PRESSED)
                        begin
                            held_cnt = '0;
                            long_start_fired = 1'b0;
                        end
                        else if (held_cnt > release_limit)
                        begin
                            long_release_flg = 1'b1;
                        end
                        else
                        begin
                            short_flg = 1'b1;
                        end
                    end
                    else if (level_db == LEVEL_PRESSED && !long_start_fired
                             && held_cnt >= long_start_limit)
                    begin
                        // once per press, whatever happens to the flag later
                        long_start_flg = 1'b1;
                        long_start_fired = 1'b1;
                    end
                end
            end
            OP_TAKE_SHORT:
            begin
                res.taken_flag = short_flg;
                short_flg = 1'b0;
            end
            OP_TAKE_START:
            begin
                res.taken_flag = long_start_flg;
                long_start_flg = 1'b0;
            end
            OP_TAKE_LONG:
            begin
                res.taken_flag = long_release_flg;
                long_release_flg = 1'b0;
            end
            OP_CLEAR_ALL:
            begin
                // the once-per-press mark survives a clear
                short_flg = 1'b0;
                long_start_flg = 1'b0;
                long_release_flg = 1'b0;
            end
            default:
            begin
            end
        endcase
        res.accepted_level = level_db;
        res.short_pending = short_flg;
        res.long_start_pending = long_start_flg;
        res.long_release_pending = long_release_flg;
        return res;
    endfunction

    // offer one request, after a random gap, and hold it until taken
    task automatic send_request(input logic [2:0] op, input logic raw);
        int gap_pct;
        case (idle_mode)
            IDLE_SENDER: gap_pct = BUSY_PCT;
            IDLE_BOTH:   gap_pct = LIGHT_PCT;
            default:     gap_pct = 0;
        endcase
        while ($urandom_range(99) < gap_pct)
        begin
            @(negedge clk);
            item_ch.valid <= 1'b0;
        end
        @(negedge clk);
        item_ch.valid <= 1'b1;
        item_ch.operation <= op;
        item_ch.raw_level <= raw;
        do
        begin
            @(posedge clk);
        end
        while (!item_ch.ready);
        pending_results.push_back(classify_request(op, raw));
        // ignored codes do not count as traffic
        if (op <= OP_CLEAR_ALL)
        begin
            requests_sent++;
        end
    endtask

    task automatic send_ticks(input logic raw, input int count);
        repeat (count)
        begin
            send_request(OP_TICK, raw);
        end
    endtask

    // stop offering, wait for every owed result, then let the pipeline settle
    task automatic drain_results();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4)
        begin
            @(posedge clk);
        end
    endtask

    // only called with the block idle
    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_BITS-1:0] data);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            CFG_DEBOUNCE:   debounce_limit = data;
            CFG_LONG_START: long_start_limit = data;
            CFG_RELEASE:    release_limit = data;
            default:
            begin
            end
        endcase
    endtask

    // every operation against the reset registers, nothing gets accepted yet
    task automatic test_reset_state();
        send_request(OP_TAKE_SHORT, LEVEL_RELEASED);
        send_request(OP_TAKE_START, LEVEL_PRESSED);
        send_request(OP_TAKE_LONG, LEVEL_RELEASED);
        send_request(OP_CLEAR_ALL, LEVEL_PRESSED);
        send_ticks(LEVEL_PRESSED, 2);
        send_ticks(LEVEL_RELEASED, 1);
        for (int code = OP_UNKNOWN_FIRST; code <= OP_UNKNOWN_LAST; code++)
        begin
            send_request(3'(code), code[0]);
        end
        send_request(OP_TICK, LEVEL_RELEASED);
    endtask

    // short thresholds: bounce, long start taken, no second long start, both releases
    task automatic test_press_sequences();
        drain_results();
        // a write to the missing register must change nothing
        write_register(CFG_UNUSED, '1);
        write_register(CFG_DEBOUNCE, 16'd1);
        write_register(CFG_LONG_START, 16'd2);
        write_register(CFG_RELEASE, 16'd3);
        send_ticks(LEVEL_PRESSED, 1);
        send_ticks(LEVEL_RELEASED, 1);
        send_ticks(LEVEL_PRESSED, 4);
        send_ticks(LEVEL_PRESSED, 3);
        send_request(OP_TAKE_START, LEVEL_PRESSED);
        send_ticks(LEVEL_PRESSED, 3);
        send_request(OP_CLEAR_ALL, LEVEL_PRESSED);
        send_ticks(LEVEL_PRESSED, 2);
        send_ticks(LEVEL_RELEASED, 3);
        send_request(OP_TAKE_SHORT, LEVEL_RELEASED);
        send_request(OP_TAKE_LONG, LEVEL_RELEASED);
        // a short press
        send_ticks(LEVEL_PRESSED, 3);
        send_ticks(LEVEL_RELEASED, 3);
        send_request(OP_TAKE_LONG, LEVEL_RELEASED);
        send_request(OP_TAKE_SHORT, LEVEL_RELEASED);
    endtask

    // all registers at zero: accept on the first steady tick, long start on the next pressed tick
    task automatic test_zero_thresholds();
        drain_results();
        write_register(CFG_DEBOUNCE, '0);
        write_register(CFG_LONG_START, '0);
        write_register(CFG_RELEASE, '0);
        send_ticks(LEVEL_PRESSED, 3);
        send_ticks(LEVEL_RELEASED, 2);
        send_request(OP_TAKE_START, LEVEL_RELEASED);
        send_ticks(LEVEL_PRESSED, 2);
        send_ticks(LEVEL_RELEASED, 2);
        send_request(OP_TAKE_LONG, LEVEL_RELEASED);
    endtask

    // result side held off for a long stretch while requests keep coming
    task automatic test_output_hold_off();
        drain_results();
        idle_mode = IDLE_NONE;
        write_register(CFG_DEBOUNCE, 16'd2);
        write_register(CFG_LONG_START, 16'd5);
        write_register(CFG_RELEASE, 16'd8);
        @(posedge clk);
        hold_left = 300;
        send_ticks(LEVEL_PRESSED, 20);
        send_request(OP_TAKE_START, LEVEL_PRESSED);
        send_ticks(LEVEL_RELEASED, 20);
        send_request(OP_TAKE_LONG, LEVEL_RELEASED);
    endtask

    // one press with bounce at both ends, flag accesses now and then, or a burst of noise
    task automatic run_press_episode();
        int hold_len;
        int rest_len;
        if ($urandom_range(9) == 0)
        begin
            repeat (6)
            begin
                send_request(3'($urandom_range(OP_UNKNOWN_LAST, OP_TICK)),
                             1'($urandom_range(1)));
            end
        end
        else
        begin
            hold_len = $urandom_range(int'(debounce_limit) + int'(long_start_limit)
                                      + int'(release_limit) + 6);
            rest_len = int'(debounce_limit) + $urandom_range(2, 5);
            repeat ($urandom_range(4))
            begin
                send_request(OP_TICK, 1'($urandom_range(1)));
            end
            repeat (hold_len)
            begin
                if ($urandom_range(7) == 0)
                begin
                    send_request(3'($urandom_range(OP_CLEAR_ALL, OP_TAKE_SHORT)),
                                 1'($urandom_range(1)));
                end
                send_request(OP_TICK, LEVEL_PRESSED);
            end
            repeat ($urandom_range(4))
            begin
                send_request(OP_TICK, 1'($urandom_range(1)));
            end
            send_ticks(LEVEL_RELEASED, rest_len);
            repeat ($urandom_range(3))
            begin
                send_request(3'($urandom_range(OP_CLEAR_ALL, OP_TAKE_SHORT)),
                             1'($urandom_range(1)));
            end
        end
    endtask

    task automatic run_random_phase(input idle_mode_t mode, input int quota);
        int start_count;
        drain_results();
        idle_mode = mode;
        write_register(CFG_DEBOUNCE, 16'($urandom_range(3)));
        write_register(CFG_LONG_START, 16'($urandom_range(12)));
        write_register(CFG_RELEASE, 16'($urandom_range(12)));
        start_count = requests_sent;
        while (requests_sent - start_count < quota)
        begin
            run_press_episode();
        end
    endtask

    // random presses under each idle pattern, new registers each phase
    task automatic test_random_traffic();
        run_random_phase(IDLE_NONE, 110);
        run_random_phase(IDLE_SENDER, 110);
        run_random_phase(IDLE_RECEIVER, 110);
        run_random_phase(IDLE_BOTH, 110);
        run_random_phase(IDLE_BOTH, 60);
    endtask

    // reset once, the tests in turn, then the verdict
    initial
    begin
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.operation = OP_TICK;
        item_ch.raw_level = LEVEL_RELEASED;
        cfg_write_en = 1'b0;
        cfg_index = CFG_DEBOUNCE;
        cfg_data = '0;
        clear_button_model();
        repeat (3)
        begin
            @(negedge clk);
        end
        rst_n = 1'b1;

        test_reset_state();
        test_press_sequences();
        test_zero_thresholds();
        test_output_hold_off();
        test_random_traffic();
        drain_results();

        if (error_count == 0)
        begin
            $display("button_debounce_press_classifier_unit_test OK");
        end
        else
        begin
            $display("button_debounce_press_classifier_unit_test NOT OK");
        end
        $finish;
    end

endmodule
